// File: rtl/core/tgt_pkg.sv
package tgt_pkg;

    // Result gesture codes
    typedef enum logic [2:0] {
        GST_NONE      = 3'd0,
        GST_DOWN      = 3'd1,
        GST_UP        = 3'd2,
        GST_SLIDE     = 3'd3,
        GST_SLIDE_END = 3'd4
    } gesture_t;

    // Tracker state; codes match the gesture codes they report
    typedef enum logic [1:0] {
        TRK_NONE  = 2'd0,
        TRK_DOWN  = 2'd1,
        TRK_SLIDE = 2'd3
    } track_state_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_SLIDE_THRESHOLD  = 2'd0;
    localparam logic [1:0] CFG_TAP_WINDOW       = 2'd1;
    localparam logic [1:0] CFG_TRANSPOSE_ENABLE = 2'd2;
    localparam logic [1:0] CFG_TRANSPOSE_SPAN   = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [7:0]  SLIDE_THRESHOLD_RST  = 8'd6;
    localparam logic [15:0] TAP_WINDOW_RST       = 16'd25;
    localparam logic        TRANSPOSE_ENABLE_RST = 1'b1;
    localparam logic [15:0] TRANSPOSE_SPAN_RST   = 16'd319;

    localparam logic [7:0]  TAP_COUNT_MAX = 8'd255;

    localparam int IN_TDATA_W  = 56;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 104;
    localparam int OUT_TUSER_W = 3;

    typedef struct packed {
        logic        pending;
        logic        contact;
        logic [11:0] raw_x;
        logic [11:0] raw_y;
        logic [31:0] now_ticks;
    } sample_t;

    typedef struct packed {
        gesture_t           gesture;
        logic [15:0]        pos_x;
        logic [15:0]        pos_y;
        logic [15:0]        begin_x;
        logic [15:0]        begin_y;
        logic signed [15:0] move_x;
        logic signed [15:0] move_y;
        logic [7:0]         taps;
    } result_t;

    typedef struct packed {
        logic                   wr_en;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_write_t;

endpackage

// File: rtl/core/tgt_in_stage.sv
module tgt_in_stage (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [tgt_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic [tgt_pkg::IN_TUSER_W-1:0] s_tuser,
    input  logic                        advance,
    output logic                        item_valid,
    output tgt_pkg::sample_t            item
);
    import tgt_pkg::*;

    logic    valid_reg;
    sample_t item_reg;

    // take a new word when the register is empty or is draining this cycle
    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.pending   <= s_tuser[0];
            item_reg.contact   <= s_tuser[1];
            item_reg.raw_x     <= s_tdata[11:0];
            item_reg.raw_y     <= s_tdata[23:12];
            item_reg.now_ticks <= s_tdata[55:24];
        end
    end

endmodule

// File: rtl/core/tgt_core.sv
module tgt_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  tgt_pkg::cfg_write_t cfg,
    input  logic                advance,
    input  tgt_pkg::sample_t    item,
    output tgt_pkg::result_t    result
);
    import tgt_pkg::*;

    // configuration
    logic [7:0]  slide_threshold_reg;
    logic [15:0] tap_window_reg;
    logic        transpose_enable_reg;
    logic [15:0] transpose_span_reg;

    // tracking state
    track_state_t state_reg, state_next;
    logic [15:0]  last_x_reg, last_x_next;
    logic [15:0]  last_y_reg, last_y_next;
    logic [15:0]  start_x_reg, start_x_next;
    logic [15:0]  start_y_reg, start_y_next;
    logic [7:0]   rep_taps_reg, rep_taps_next;
    logic [31:0]  press_time_reg, press_time_next;
    logic [31:0]  last_tap_reg, last_tap_next;
    logic [7:0]   tap_cnt_reg, tap_cnt_next;

    logic [15:0]        cur_x;
    logic [15:0]        cur_y;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [16:0] th_pos;
    logic signed [16:0] th_neg;
    logic               slide_hit;
    logic [31:0]        press_age;
    logic [31:0]        tap_gap;
    logic               press_short;
    logic               gap_long;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slide_threshold_reg  <= SLIDE_THRESHOLD_RST;
            tap_window_reg       <= TAP_WINDOW_RST;
            transpose_enable_reg <= TRANSPOSE_ENABLE_RST;
            transpose_span_reg   <= TRANSPOSE_SPAN_RST;
        end else if (cfg.wr_en) begin
            case (cfg.index)
                CFG_SLIDE_THRESHOLD:  slide_threshold_reg  <= cfg.data[7:0];
                CFG_TAP_WINDOW:       tap_window_reg       <= cfg.data;
                CFG_TRANSPOSE_ENABLE: transpose_enable_reg <= cfg.data[0];
                CFG_TRANSPOSE_SPAN:   transpose_span_reg   <= cfg.data;
                default: ;
            endcase
        end
    end

    // rotate by ninety degrees when enabled; span - x wraps at 16 bits
    always_comb begin
        if (transpose_enable_reg) begin
            cur_x = {4'd0, item.raw_y};
            cur_y = transpose_span_reg - {4'd0, item.raw_x};
        end else begin
            cur_x = {4'd0, item.raw_x};
            cur_y = {4'd0, item.raw_y};
        end
    end

    assign dx        = $signed({1'b0, cur_x}) - $signed({1'b0, last_x_reg});
    assign dy        = $signed({1'b0, cur_y}) - $signed({1'b0, last_y_reg});
    assign th_pos    = $signed({9'd0, slide_threshold_reg});
    assign th_neg    = -th_pos;
    assign slide_hit = (dx >= th_pos) || (dx <= th_neg) || (dy >= th_pos) || (dy <= th_neg);

    assign press_age   = item.now_ticks - press_time_reg;
    assign tap_gap     = item.now_ticks - last_tap_reg;
    assign press_short = press_age <= {16'd0, tap_window_reg};
    assign gap_long    = tap_gap > {16'd0, tap_window_reg};

    always_comb begin
        state_next      = state_reg;
        last_x_next     = last_x_reg;
        last_y_next     = last_y_reg;
        start_x_next    = start_x_reg;
        start_y_next    = start_y_reg;
        rep_taps_next   = rep_taps_reg;
        press_time_next = press_time_reg;
        last_tap_next   = last_tap_reg;
        tap_cnt_next    = tap_cnt_reg;
        result.gesture  = gesture_t'({1'b0, state_reg});
        result.move_x   = '0;
        result.move_y   = '0;

        if (item.pending) begin
            rep_taps_next = '0;
            if (item.contact) begin
                last_x_next = cur_x;
                last_y_next = cur_y;
                case (state_reg)
                    TRK_NONE: begin
                        start_x_next = cur_x;
                        start_y_next = cur_y;
                        state_next   = TRK_DOWN;
                    end
                    TRK_DOWN: begin
                        if (slide_hit) begin
                            state_next    = TRK_SLIDE;
                            result.move_x = dx[15:0];
                            result.move_y = dy[15:0];
                        end
                    end
                    default: begin
                        result.move_x = dx[15:0];
                        result.move_y = dy[15:0];
                    end
                endcase
                // zero press time means unstamped
                if (state_next == TRK_DOWN && press_time_reg == '0) begin
                    press_time_next = item.now_ticks;
                end
                result.gesture = gesture_t'({1'b0, state_next});
            end else begin
                if (state_reg == TRK_DOWN) begin
                    result.gesture = GST_UP;
                    if (press_short) begin
                        if (gap_long) begin
                            tap_cnt_next = 8'd1;
                        end else if (tap_cnt_reg != TAP_COUNT_MAX) begin
                            tap_cnt_next = tap_cnt_reg + 8'd1;
                        end
                        rep_taps_next = tap_cnt_next;
                        last_tap_next = item.now_ticks;
                    end
                    press_time_next = '0;
                end else begin
                    tap_cnt_next   = '0;
                    result.gesture = GST_SLIDE_END;
                end
                state_next = TRK_NONE;
            end
        end

        result.pos_x   = last_x_next;
        result.pos_y   = last_y_next;
        result.begin_x = start_x_next;
        result.begin_y = start_y_next;
        result.taps    = rep_taps_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= TRK_NONE;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            start_x_reg    <= '0;
            start_y_reg    <= '0;
            rep_taps_reg   <= '0;
            press_time_reg <= '0;
            last_tap_reg   <= '0;
            tap_cnt_reg    <= '0;
        end else if (advance) begin
            last_x_reg     <= last_x_next;
            last_y_reg     <= last_y_next;
            start_x_reg    <= start_x_next;
            start_y_reg    <= start_y_next;
            rep_taps_reg   <= rep_taps_next;
            press_time_reg <= press_time_next;
            last_tap_reg   <= last_tap_next;
            tap_cnt_reg    <= tap_cnt_next;
        end
    end

    a_taps_only_on_up: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item.pending && result.gesture != GST_UP |-> result.taps == '0)
        else $error("taps reported without an up");

    a_move_only_on_slide: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (result.move_x != '0 || result.move_y != '0)
        |-> result.gesture == GST_SLIDE)
        else $error("movement reported outside a slide");

    a_release_to_none: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item.pending && !item.contact |=> state_reg == TRK_NONE)
        else $error("release did not return to none");

    a_slide_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && result.gesture == GST_SLIDE_END |=> tap_cnt_reg == '0)
        else $error("slide end kept the tap count");

    a_hold_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance && !$past(cfg.wr_en) |=> $stable(state_reg) && $stable(press_time_reg))
        else $error("state moved without an item");

endmodule

// File: rtl/core/tgt_out_stage.sv
module tgt_out_stage (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          item_valid,
    input  tgt_pkg::result_t              result,
    output logic                          advance,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tgt_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic [tgt_pkg::OUT_TUSER_W-1:0] m_tuser
);
    import tgt_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    // load while empty or while the held word is being taken
    assign advance = item_valid && (!valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (!valid_reg || m_tready) begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = result_reg.gesture;
    assign m_tdata  = {result_reg.taps, result_reg.move_y, result_reg.move_x,
                       result_reg.begin_y, result_reg.begin_x,
                       result_reg.pos_y, result_reg.pos_x};

endmodule

// File: rtl/core/touch_gesture_tracker_unit.sv
// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid/s_tready    tuser: pending, contact; tdata: raw_x, raw_y, now_ticks
// m_        out  m_tvalid/m_tready    tuser: gesture; tdata: pos, begin, move, taps
// cfg_      in   cfg_wr_en            cfg_index selects register, cfg_data value
//
// One sample per cycle sustained while the output is not stalled; each sample passes
// through the input register, the tracker logic and the output register, in that order.
// The tracker state updates when a sample moves into the output register, so
// back-to-back samples see the state left by the one before.
// A stalled output holds its word and the input register; s_tready drops only
// when both are full. Reset is synchronous.
module touch_gesture_tracker_unit (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [tgt_pkg::IN_TDATA_W-1:0]          s_tdata,   // raw_x, raw_y, now_ticks
    input  logic [tgt_pkg::IN_TUSER_W-1:0]          s_tuser,   // pending, contact
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [tgt_pkg::OUT_TDATA_W-1:0]         m_tdata,   // pos_x, pos_y, begin_x,
                                                               // begin_y, move_x, move_y, taps
    output logic [tgt_pkg::OUT_TUSER_W-1:0]         m_tuser,   // gesture
    input  logic                                    cfg_wr_en,
    input  logic [tgt_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [tgt_pkg::CFG_DATA_W-1:0]          cfg_data
);
    import tgt_pkg::*;

    logic       advance;
    logic       item_valid;
    sample_t    item;
    result_t    result;
    cfg_write_t cfg;

    assign cfg.wr_en = cfg_wr_en;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    tgt_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    tgt_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    tgt_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

// File: tb/sv/touch_gesture_tracker_unit_test.sv
`timescale 1ns / 1ps

module touch_gesture_tracker_unit_test;
    import tgt_pkg::*;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // raw_x, raw_y, now_ticks
    logic [IN_TUSER_W-1:0]  s_tuser;   // pending, contact
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // pos_x, pos_y, begin_x, begin_y, move_x, move_y, taps
    logic [OUT_TUSER_W-1:0] m_tuser;   // gesture
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    touch_gesture_tracker_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // tracker settings as the block should hold them
    logic [7:0]   slide_thr;
    logic [15:0]  tap_win;
    logic         rotate_en;
    logic [15:0]  rotate_span;

    // tracker state as the block should hold it
    track_state_t touch_phase;
    logic [15:0]  prev_x, prev_y;
    logic [15:0]  anchor_x, anchor_y;
    logic [7:0]   shown_taps;
    logic [7:0]   tap_run;
    logic [31:0]  press_stamp;
    logic [31:0]  tap_stamp;

    result_t      gesture_results[$];
    logic [31:0]  tick_now;
    bit           src_burst;
    bit           sink_burst;
    int           samples_sent;
    int           mismatches;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("touch_gesture_tracker_unit_test failed");
        $finish;
    end

    function automatic result_t track_touch(input logic pending, input logic contact,
                                            input logic [11:0] rx, input logic [11:0] ry,
                                            input logic [31:0] now);
        result_t     res;
        logic [15:0] x, y;
        int          dx, dy, thr;
        logic [31:0] held, since_tap;
        res = '0;
        if (!pending) begin
            res.gesture = gesture_t'({1'b0, touch_phase});
        end else begin
            shown_taps = '0;
            if (rotate_en) begin
                x = {4'd0, ry};
                y = rotate_span - {4'd0, rx};
            end else begin
                x = {4'd0, rx};
                y = {4'd0, ry};
            end
            if (contact) begin
                dx  = int'(x) - int'(prev_x);
                dy  = int'(y) - int'(prev_y);
                thr = int'(slide_thr);
                prev_x = x;
                prev_y = y;
                case (touch_phase)
                    TRK_NONE: begin
                        anchor_x    = x;
                        anchor_y    = y;
                        touch_phase = TRK_DOWN;
                    end
                    TRK_DOWN: begin
                        if (dx >= thr || dx <= -thr || dy >= thr || dy <= -thr) begin
                            touch_phase = TRK_SLIDE;
                            res.move_x  = dx[15:0];
                            res.move_y  = dy[15:0];
                        end
                    end
                    default: begin
                        res.move_x = dx[15:0];
                        res.move_y = dy[15:0];
                    end
                endcase
                // a zero stamp means unset, so stamp again
                if (touch_phase == TRK_DOWN && press_stamp == '0)
                    press_stamp = now;
                res.gesture = gesture_t'({1'b0, touch_phase});
            end else begin
                if (touch_phase == TRK_DOWN) begin
                    res.gesture = GST_UP;
                    held      = now - press_stamp;
                    since_tap = now - tap_stamp;
                    if (held <= {16'd0, tap_win}) begin
                        if (since_tap > {16'd0, tap_win})
                            tap_run = 8'd1;
                        else if (tap_run != TAP_COUNT_MAX)
                            tap_run = tap_run + 8'd1;
                        shown_taps = tap_run;
                        tap_stamp  = now;
                    end
                    press_stamp = '0;
                end else begin
                    tap_run     = '0;
                    res.gesture = GST_SLIDE_END;
                end
                touch_phase = TRK_NONE;
            end
        end
        res.pos_x   = prev_x;
        res.pos_y   = prev_y;
        res.begin_x = anchor_x;
        res.begin_y = anchor_y;
        res.taps    = shown_taps;
        return res;
    endfunction

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] seen);
        if (want !== seen) begin
            if (mismatches < 10)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : check_result
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (gesture_results.size() == 0) begin
                if (mismatches < 10)
                    $display("%0t: result word with nothing expected, got %0h / %0h",
                             $time, m_tuser, m_tdata);
                mismatches++;
            end else begin
                want = gesture_results.pop_front();
                compare_field("gesture", 16'(want.gesture), 16'(m_tuser));
                compare_field("pos_x",   want.pos_x,   m_tdata[15:0]);
                compare_field("pos_y",   want.pos_y,   m_tdata[31:16]);
                compare_field("begin_x", want.begin_x, m_tdata[47:32]);
                compare_field("begin_y", want.begin_y, m_tdata[63:48]);
                compare_field("move_x",  want.move_x,  m_tdata[79:64]);
                compare_field("move_y",  want.move_y,  m_tdata[95:80]);
                compare_field("taps",    16'(want.taps), 16'(m_tdata[103:96]));
            end
        end
    end

    // result side: draw a stall per word, with stretches of none
    initial begin : result_sink
        int stall;
        int stretch;
        m_tready <= 1'b0;
        stretch = 0;
        @(posedge aclk);
        forever begin
            if (stretch == 0) begin
                sink_burst = ($urandom_range(0, 3) == 0);
                stretch    = $urandom_range(10, 60);
            end
            stretch--;
            stall = sink_burst ? 0 : $urandom_range(0, 16);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_sample(input logic pending, input logic contact,
                               input logic [11:0] rx, input logic [11:0] ry, input int dt);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 16);
        tick_now += dt;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {contact, pending};
        s_tdata  <= {tick_now, ry, rx};
        do @(posedge aclk); while (!s_tready);
        gesture_results.push_back(track_touch(pending, contact, rx, ry, tick_now));
        samples_sent++;
    endtask

    // hold the input until every expected word is out
    task automatic settle_results();
        int waited;
        s_tvalid <= 1'b0;
        waited = 0;
        while (gesture_results.size() != 0 && waited < 4000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_setup(input logic [7:0] thr, input logic [15:0] win,
                               input logic rot, input logic [15:0] span);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SLIDE_THRESHOLD;
        cfg_data  <= {8'd0, thr};
        @(posedge aclk);
        cfg_index <= CFG_TAP_WINDOW;
        cfg_data  <= win;
        @(posedge aclk);
        cfg_index <= CFG_TRANSPOSE_ENABLE;
        cfg_data  <= {15'd0, rot};
        @(posedge aclk);
        cfg_index <= CFG_TRANSPOSE_SPAN;
        cfg_data  <= span;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        slide_thr   = thr;
        tap_win     = win;
        rotate_en   = rot;
        rotate_span = span;
    endtask

    task automatic apply_reset();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        slide_thr   = SLIDE_THRESHOLD_RST;
        tap_win     = TAP_WINDOW_RST;
        rotate_en   = TRANSPOSE_ENABLE_RST;
        rotate_span = TRANSPOSE_SPAN_RST;
        touch_phase = TRK_NONE;
        prev_x      = '0;
        prev_y      = '0;
        anchor_x    = '0;
        anchor_y    = '0;
        shown_taps  = '0;
        tap_run     = '0;
        press_stamp = '0;
        tap_stamp   = '0;
        @(posedge aclk);
    endtask

    task automatic test_directed_touches();
        src_burst = 1'b0;
        tick_now  = '0;
        send_sample(1'b0, 1'b1, 12'hFFF, 12'hFFF, 0);  // nothing pending, contact set
        send_sample(1'b1, 1'b1, 12'd0, 12'd0, 0);      // press at tick zero
        send_sample(1'b1, 1'b1, 12'd0, 12'd0, 3);
        send_sample(1'b1, 1'b0, 12'd0, 12'd0, 3);      // first tap
        send_sample(1'b0, 1'b0, 12'd0, 12'd0, 1);
        send_sample(1'b1, 1'b1, 12'hFFF, 12'hFFF, 3);
        send_sample(1'b1, 1'b0, 12'hFFF, 12'hFFF, 2);  // second tap
        send_sample(1'b1, 1'b1, 12'd100, 12'd100, 2);
        send_sample(1'b1, 1'b1, 12'd105, 12'd100, 1);  // just under the threshold
        send_sample(1'b1, 1'b1, 12'd105, 12'd106, 1);  // at the threshold
        send_sample(1'b1, 1'b1, 12'd0, 12'hFFF, 1);
        send_sample(1'b1, 1'b1, 12'hFFF, 12'd0, 1);
        send_sample(1'b0, 1'b1, 12'd0, 12'd0, 1);
        send_sample(1'b1, 1'b0, 12'd7, 12'd9, 1);      // slide end
        send_sample(1'b1, 1'b0, 12'd7, 12'd9, 1);      // lift with nothing pressed
        send_sample(1'b1, 1'b1, 12'd50, 12'd60, 6);    // keeps the stamp left by the slide
        send_sample(1'b1, 1'b0, 12'd50, 12'd60, 25);
        tick_now = 32'hFFFF_FFF0;
        send_sample(1'b1, 1'b1, 12'd200, 12'd300, 0);
        send_sample(1'b1, 1'b0, 12'd200, 12'd300, 18); // held across the tick wrap
        send_sample(1'b1, 1'b1, 12'd200, 12'd300, 1);
        send_sample(1'b1, 1'b1, 12'd206, 12'd294, 1);  // negative move at the threshold
        send_sample(1'b1, 1'b0, 12'd0, 12'd0, 1);
        settle_results();
    endtask

    task automatic test_config_extremes();
        write_setup(8'd0, 16'd0, 1'b0, 16'd0);
        send_sample(1'b1, 1'b1, 12'd10, 12'd20, 5);
        send_sample(1'b1, 1'b1, 12'd10, 12'd20, 0);    // zero threshold slides on no movement
        send_sample(1'b1, 1'b0, 12'd10, 12'd20, 1);
        send_sample(1'b1, 1'b1, 12'hFFF, 12'd0, 3);
        send_sample(1'b1, 1'b0, 12'hFFF, 12'd0, 0);    // release outside a zero window, no tap
        settle_results();
        write_setup(8'd255, 16'hFFFF, 1'b1, 16'hFFFF);
        send_sample(1'b1, 1'b1, 12'd0, 12'd0, 1);
        send_sample(1'b1, 1'b1, 12'd0, 12'd254, 1);
        send_sample(1'b1, 1'b1, 12'd0, 12'd509, 1);
        send_sample(1'b1, 1'b0, 12'd0, 12'd509, 1);
        send_sample(1'b1, 1'b1, 12'hFFF, 12'hFFF, 1);
        send_sample(1'b1, 1'b0, 12'hFFF, 12'hFFF, 1);
        settle_results();
    endtask

    task automatic test_tap_saturation();
        write_setup(SLIDE_THRESHOLD_RST, 16'hFFFF, 1'b0, TRANSPOSE_SPAN_RST);
        repeat (262) begin
            src_burst = 1'($urandom());
            send_sample(1'b1, 1'b1, 12'($urandom()), 12'($urandom()), 1);
            send_sample(1'b1, 1'b0, 12'($urandom()), 12'($urandom()), 1);
        end
        settle_results();
    endtask

    task automatic run_gesture();
        int          kind;
        int          reach;
        logic [11:0] rx, ry;
        kind      = $urandom_range(0, 9);
        reach     = (kind < 6) ? 4 : 80;
        src_burst = ($urandom_range(0, 4) == 0);
        rx        = 12'($urandom());
        ry        = 12'($urandom());
        if ($urandom_range(0, 19) == 0)
            tick_now = $urandom();
        if (kind == 0) begin
            repeat ($urandom_range(1, 4))
                send_sample(1'($urandom()), 1'($urandom()), 12'($urandom()),
                            12'($urandom()), $urandom_range(0, 40));
        end else if (kind == 1) begin
            send_sample(1'b1, 1'b0, rx, ry, $urandom_range(0, 10));
        end else begin
            send_sample(1'b1, 1'b1, rx, ry, $urandom_range(0, 30));
            repeat ((kind < 6) ? $urandom_range(0, 2) : $urandom_range(1, 12)) begin
                if ($urandom_range(0, 7) == 0) begin
                    send_sample(1'b0, 1'($urandom()), rx, ry, $urandom_range(0, 3));
                end else begin
                    rx = rx + 12'($urandom_range(0, 2 * reach)) - 12'(reach);
                    ry = ry + 12'($urandom_range(0, 2 * reach)) - 12'(reach);
                    send_sample(1'b1, 1'b1, rx, ry, $urandom_range(0, 4));
                end
            end
            // leave some presses open so the next one lands on a live touch
            if ($urandom_range(0, 9) != 0)
                send_sample(1'b1, 1'b0, 12'($urandom()), 12'($urandom()),
                            $urandom_range(0, 8));
        end
        if ($urandom_range(0, 39) == 0)
            settle_results();
    endtask

    task automatic test_random_gestures();
        int phase;
        int phase_start;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_setup(SLIDE_THRESHOLD_RST, TAP_WINDOW_RST, TRANSPOSE_ENABLE_RST,
                               TRANSPOSE_SPAN_RST);
                1: write_setup(8'd1, 16'hFFFF, 1'b0, 16'd0);
                2: write_setup(8'd255, 16'd0, 1'b1, 16'hFFFF);
                default: write_setup(8'($urandom()),
                                     $urandom_range(0, 1) ? 16'($urandom_range(0, 60))
                                                          : 16'($urandom()),
                                     1'($urandom()), 16'($urandom()));
            endcase
            phase_start = samples_sent;
            while (samples_sent - phase_start < 25)
                run_gesture();
            settle_results();
        end
    endtask

    initial begin
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= '0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= CFG_SLIDE_THRESHOLD;
        cfg_data     <= '0;
        samples_sent = 0;
        mismatches   = 0;
        tick_now     = '0;
        src_burst    = 1'b0;
        apply_reset();
        test_directed_touches();
        test_config_extremes();
        test_tap_saturation();
        test_random_gestures();
        settle_results();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && gesture_results.size() == 0) begin
            $display("touch_gesture_tracker_unit_test passed");
        end else begin
            $display("touch_gesture_tracker_unit_test failed");
        end
        $finish;
    end

endmodule

// File: touch_gesture_tracker_unit.f
rtl/core/tgt_pkg.sv
rtl/core/tgt_in_stage.sv
rtl/core/tgt_core.sv
rtl/core/tgt_out_stage.sv
rtl/core/touch_gesture_tracker_unit.sv
tb/sv/touch_gesture_tracker_unit_test.sv
